@@ src/lrup_pkg.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement package
// Shared widths, the result and request records, and small helper functions.
// ----------------------------------------------------------------------------
package lrup_pkg;

    localparam int MAX_FRAMES  = 16;
    localparam int PAGE_BITS   = 16;
    localparam int FRAME_BITS  = $clog2(MAX_FRAMES);
    localparam int COUNT_BITS  = $clog2(MAX_FRAMES + 1);
    localparam int CFG_BITS    = 5;
    localparam int FAULT_BITS  = 32;
    localparam int FRAMES_RESET = 4;

    typedef struct packed {
        logic                 fire;
        logic [PAGE_BITS-1:0] page;
    } lrup_req_t;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame_index;
        logic                  evicted_valid;
        logic [PAGE_BITS-1:0]  evicted_page;
        logic [FAULT_BITS-1:0] fault_total;
    } lrup_result_t;

    // Zero acts as one, anything above the frame count as the frame count.
    function automatic logic [COUNT_BITS-1:0] clamp_frames(input logic [CFG_BITS-1:0] v);
        logic [COUNT_BITS-1:0] n;
        if (v == '0) begin
            n = COUNT_BITS'(1);
        end else if (int'(v) > MAX_FRAMES) begin
            n = COUNT_BITS'(MAX_FRAMES);
        end else begin
            n = COUNT_BITS'(v);
        end
        return n;
    endfunction

    function automatic logic [FRAME_BITS-1:0] lowest_set(input logic [MAX_FRAMES-1:0] v);
        logic [FRAME_BITS-1:0] idx;
        idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = FRAME_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ src/lrup_in_stage.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement input stage
// Registers one incoming page reference and hands it on when the set advances.
// ----------------------------------------------------------------------------
module lrup_in_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lrup_pkg::PAGE_BITS-1:0] s_page_number,
    input  logic                          out_free,
    output lrup_pkg::lrup_req_t           req
);
    import lrup_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 advance;

    assign advance = valid_reg && out_free;
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            page_reg <= s_page_number;
        end
    end

    assign req.fire = advance;
    assign req.page = page_reg;

endmodule

@@ src/lrup_frame_set.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement frame set
// Holds the frames with their ages, looks up one page and updates recency.
// ----------------------------------------------------------------------------
module lrup_frame_set (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lrup_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  lrup_pkg::lrup_req_t           req,
    output lrup_pkg::lrup_result_t        result
);
    import lrup_pkg::*;

    logic [COUNT_BITS-1:0] n_reg;
    logic [MAX_FRAMES-1:0] valid_reg;
    logic [MAX_FRAMES-1:0] valid_next;
    logic [FRAME_BITS-1:0] age_reg  [MAX_FRAMES];
    logic [FRAME_BITS-1:0] age_next [MAX_FRAMES];
    logic [PAGE_BITS-1:0]  pages_reg [MAX_FRAMES];
    logic [FAULT_BITS-1:0] fault_reg;
    logic [FAULT_BITS-1:0] fault_next;

    logic [MAX_FRAMES-1:0] in_use;
    logic [MAX_FRAMES-1:0] match_vec;
    logic [MAX_FRAMES-1:0] free_vec;
    logic [MAX_FRAMES-1:0] lru_vec;
    logic [MAX_FRAMES-1:0] bump_vec;
    logic                  hit;
    logic                  free_found;
    logic [FRAME_BITS-1:0] sel;
    logic [FRAME_BITS-1:0] sel_age;

    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            in_use[i]    = COUNT_BITS'(i) < n_reg;
            match_vec[i] = in_use[i] && valid_reg[i] && (pages_reg[i] == req.page);
            free_vec[i]  = in_use[i] && !valid_reg[i];
            lru_vec[i]   = in_use[i] && valid_reg[i]
                           && (COUNT_BITS'(age_reg[i]) == n_reg - COUNT_BITS'(1));
        end
        hit        = |match_vec;
        free_found = |free_vec;
        priority if (hit) begin
            sel = lowest_set(match_vec);
        end else if (free_found) begin
            sel = lowest_set(free_vec);
        end else begin
            sel = lowest_set(lru_vec);
        end
        sel_age = age_reg[sel];
        for (int i = 0; i < MAX_FRAMES; i++) begin
            bump_vec[i] = in_use[i] && valid_reg[i] && (FRAME_BITS'(i) != sel)
                          && (!hit || (age_reg[i] < sel_age));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        fault_next = fault_reg;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            age_next[i] = age_reg[i];
        end
        if (cfg_wr_en) begin
            valid_next = '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                age_next[i] = '0;
            end
        end else if (req.fire) begin
            valid_next[sel] = 1'b1;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                if (FRAME_BITS'(i) == sel) begin
                    age_next[i] = '0;
                end else if (bump_vec[i]) begin
                    age_next[i] = age_reg[i] + FRAME_BITS'(1);
                end
            end
            if (!hit && (fault_reg != '1)) begin
                fault_next = fault_reg + FAULT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg     <= clamp_frames(CFG_BITS'(FRAMES_RESET));
            valid_reg <= '0;
            fault_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                age_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                n_reg <= clamp_frames(cfg_wr_data);
            end
            valid_reg <= valid_next;
            fault_reg <= fault_next;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                age_reg[i] <= age_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.fire && !cfg_wr_en && !hit) begin
            pages_reg[sel] <= req.page;
        end
    end

    assign result.hit           = hit;
    assign result.frame_index   = sel;
    assign result.evicted_valid = !hit && !free_found;
    assign result.evicted_page  = (!hit && !free_found) ? pages_reg[sel] : '0;
    assign result.fault_total   = fault_next;

    a_match_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("page resident in more than one frame");

    a_lru_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.fire && !hit && !free_found) |-> $onehot(lru_vec))
        else $error("no single least recently used frame in a full set");

    a_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> (valid_reg == '0))
        else $error("frames not flushed after a register write");

    a_in_use_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & ~in_use) == '0)
        else $error("valid frame outside the frames in use");

endmodule

@@ src/lrup_out_stage.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement output stage
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module lrup_out_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  lrup_pkg::lrup_result_t      result,
    output logic                        out_free,
    output logic                        m_valid,
    input  logic                        m_ready,
    output lrup_pkg::lrup_result_t      m_result
);
    import lrup_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    lrup_result_t result_reg;

    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

@@ src/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative page-frame set with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    page_number
//  m_        out        m_valid / m_ready    hit, frame_index, evicted_valid,
//                                            evicted_page, fault_total
//  cfg_      in         cfg_wr_en            frames_in_use (flushes frames)
//
//  One item per cycle while m_ready is high; an accepted item passes the input
//  register, then lookup and update into the result register.
//  Reset: frames in use 4, all frames empty, fault count zero.
//  m_ready low holds the result; one more item waits in the input register,
//  then s_ready drops.
// ----------------------------------------------------------------------------
module lru_page_replacement (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [lrup_pkg::CFG_BITS-1:0]    cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [lrup_pkg::PAGE_BITS-1:0]   s_page_number,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [lrup_pkg::FRAME_BITS-1:0]  m_frame_index,
    output logic                             m_evicted_valid,
    output logic [lrup_pkg::PAGE_BITS-1:0]   m_evicted_page,
    output logic [lrup_pkg::FAULT_BITS-1:0]  m_fault_total
);
    import lrup_pkg::*;

    lrup_req_t    req;
    lrup_result_t result;
    lrup_result_t m_result;
    logic         out_free;

    lrup_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page_number (s_page_number),
        .out_free      (out_free),
        .req           (req)
    );

    lrup_frame_set u_frame_set (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .result      (result)
    );

    lrup_out_stage u_out_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (req.fire),
        .result   (result),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_hit           = m_result.hit;
    assign m_frame_index   = m_result.frame_index;
    assign m_evicted_valid = m_result.evicted_valid;
    assign m_evicted_page  = m_result.evicted_page;
    assign m_fault_total   = m_result.fault_total;

endmodule
